/* src/ebfj_pkg.sv */
// ----------------------------------------------------------------------------
// ebfj_pkg
// Shared types and constants for the exponential backoff delay generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ebfj_pkg;

  localparam int WORD_W  = 32;
  localparam int MS_W    = 31;
  localparam int CNT_W   = $clog2(WORD_W + 1);
  localparam int CIDX_W  = 3;

  // Request codes
  localparam logic [1:0] REQ_NEXT    = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_RANDOM  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_REJECTED  = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MIN_DELAY     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_INIT_CEILING  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_DELAY     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ATTEMPT_LIMIT = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_RETRY_FOREVER = 3'd4;

  localparam logic [WORD_W-1:0] DELAY_INFINITE = '1;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic commit;
  } ebfj_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } ebfj_stat_t;

endpackage

`default_nettype wire

/* src/exponential_backoff_full_jitter_top.sv */
// ----------------------------------------------------------------------------
// exponential_backoff_full_jitter_top
// Retry delay generator with exponential ceiling growth and full jitter.
// ----------------------------------------------------------------------------
// Usage:
//   Request items arrive on s_*: s_tuser carries the request kind, s_tdata the
//   32-bit random word. Each request yields one result item on m_*: m_tuser
//   holds status and the restart suspicion flag, m_tdata the delay, attempt
//   count and next ceiling.
//   The user writes settings through cfg_valid/cfg_index/cfg_data (always
//   ready) only while the block is idle; the block does not enforce this.
// Sequence:
//   A request that needs a random draw over a non-empty range passes from
//   accept through a setup step, the bit-serial remainder unit and a commit
//   step into the result register; requests with no draw skip the remainder
//   unit. One request is in flight at a time; the next is accepted once the
//   previous result is in the output register.
// Reset clears settings, attempt count and ceiling, and drops m_tvalid.
// When the receiver stalls, the result holds in the output register and a
// following request waits in its commit step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module exponential_backoff_full_jitter_top
  import ebfj_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  // request stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [31:0]       s_tdata,   // [31:0] random_word
  input  wire logic [1:0]        s_tuser,   // [1:0] req_type
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [95:0]            m_tdata,   // [31:0] delay_ms, [63:32] attempts_done,
                                            // [94:64] next_ceiling_ms, [95] zero
  output logic [2:0]             m_tuser    // [1:0] status, [2] settings_suspicious
);

  ebfj_cmd_t  cmd;
  ebfj_stat_t stat;

  assign cfg_ready = 1'b1;

  ebfj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ebfj_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

/* src/ebfj_rem.sv */
// ----------------------------------------------------------------------------
// ebfj_rem
// Serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ebfj_rem
  import ebfj_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   busy,
  output logic [WORD_W-1:0]      remainder
);

  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W-1:0] part;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  // shift in the next dividend bit and trial subtract
  assign shifted = {part, dvd[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign busy    = (cnt != '0);
  assign remainder = part;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(WORD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      part <= '0;
    end else if (busy) begin
      dvd <= {dvd[WORD_W-2:0], 1'b0};
      if (shifted >= {1'b0, dsr}) begin
        part <= diff[WORD_W-1:0];
      end else begin
        part <= shifted[WORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* src/ebfj_dp.sv */
// ----------------------------------------------------------------------------
// ebfj_dp
// Datapath: settings, attempt/ceiling state, draw logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebfj_dp
  import ebfj_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  input  wire logic [31:0]       s_tdata,   // [31:0] random_word
  input  wire logic [1:0]        s_tuser,   // [1:0] req_type
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output logic [95:0]            m_tdata,   // [31:0] delay_ms, [63:32] attempts_done,
                                            // [94:64] next_ceiling_ms, [95] zero
  output logic [2:0]             m_tuser,   // [1:0] status, [2] settings_suspicious
  input  wire ebfj_cmd_t         cmd,
  output ebfj_stat_t             stat
);

  // settings
  logic [MS_W-1:0]   min_delay;
  logic [MS_W-1:0]   init_ceiling;
  logic [MS_W-1:0]   max_delay;
  logic [WORD_W-1:0] attempt_limit;
  logic              retry_forever;

  // backoff state and latched request
  logic [WORD_W-1:0] attempt_count;
  logic [MS_W-1:0]   ceiling;
  logic [1:0]        req_q;
  logic [WORD_W-1:0] word_q;

  // draw signals
  logic              allowed;
  logic              draw_used;
  logic [MS_W-1:0]   lo;
  logic [MS_W-1:0]   hi;
  logic              empty;
  logic [WORD_W-1:0] range_sz;
  logic              div_busy;
  logic [WORD_W-1:0] rem;
  logic [MS_W-1:0]   draw_val;
  logic [WORD_W:0]   reject_chk;
  logic              draw_ok;

  // results
  logic [1:0]        res_status;
  logic [WORD_W-1:0] res_delay;
  logic              res_susp;
  logic [WORD_W-1:0] count_next;
  logic [MS_W-1:0]   ceiling_next;

  // settings writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay     <= '0;
      init_ceiling  <= '0;
      max_delay     <= '0;
      attempt_limit <= '0;
      retry_forever <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_DELAY:     min_delay     <= cfg_data[MS_W-1:0];
        CFG_INIT_CEILING:  init_ceiling  <= cfg_data[MS_W-1:0];
        CFG_MAX_DELAY:     max_delay     <= cfg_data[MS_W-1:0];
        CFG_ATTEMPT_LIMIT: attempt_limit <= cfg_data;
        CFG_RETRY_FOREVER: retry_forever <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q  <= s_tuser;
      word_q <= s_tdata;
    end
  end

  // draw bounds per request kind
  assign allowed = retry_forever || (attempt_count < attempt_limit);

  always_comb begin
    draw_used = 1'b0;
    lo        = '0;
    hi        = '0;
    unique case (req_q)
      REQ_NEXT: begin
        draw_used = allowed;
        lo        = min_delay;
        hi        = ceiling;
      end
      REQ_RESTART: begin
        draw_used = (init_ceiling == '0);
        hi        = max_delay;
      end
      REQ_RANDOM: begin
        draw_used = 1'b1;
        lo        = init_ceiling;
        hi        = max_delay;
      end
      default: ;
    endcase
  end

  assign empty    = (lo >= hi);
  assign range_sz = {1'b0, hi} - {1'b0, lo} + WORD_W'(1);

  ebfj_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (word_q),
    .divisor   (range_sz),
    .busy      (div_busy),
    .remainder (rem)
  );

  // accept the word only if its block of range_sz values fits under 2^32
  assign reject_chk = ({1'b0, word_q} - {1'b0, rem}) + {1'b0, range_sz};
  assign draw_ok    = empty || !reject_chk[WORD_W];
  assign draw_val   = empty ? lo : (lo + rem[MS_W-1:0]);

  // result and next state
  always_comb begin
    res_status   = STAT_OK;
    res_delay    = '0;
    res_susp     = 1'b0;
    count_next   = attempt_count;
    ceiling_next = ceiling;
    unique case (req_q)
      REQ_NEXT: begin
        if (!allowed) begin
          res_status = STAT_EXHAUSTED;
          res_delay  = DELAY_INFINITE;
        end else if (draw_ok) begin
          res_delay  = {1'b0, draw_val};
          count_next = attempt_count + 1'b1;
          if (ceiling < (max_delay >> 1)) begin
            ceiling_next = {ceiling[MS_W-2:0], 1'b0};
          end else begin
            ceiling_next = max_delay;
          end
        end else begin
          res_status = STAT_REJECTED;
        end
      end
      REQ_RESTART: begin
        res_susp = (min_delay > init_ceiling) || (min_delay > max_delay) ||
                   (init_ceiling > max_delay);
        if (init_ceiling != '0) begin
          count_next   = '0;
          ceiling_next = init_ceiling;
        end else if (draw_ok) begin
          count_next   = '0;
          ceiling_next = draw_val;
        end else begin
          res_status = STAT_REJECTED;
        end
      end
      REQ_RANDOM: begin
        if (draw_ok) begin
          res_delay = {1'b0, draw_val};
        end else begin
          res_status = STAT_REJECTED;
        end
      end
      default: ;
    endcase
  end

  // state update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_count <= '0;
      ceiling       <= '0;
    end else if (cmd.commit) begin
      attempt_count <= count_next;
      ceiling       <= ceiling_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      priority if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {1'b0, ceiling_next, count_next, res_delay};
      m_tuser <= {res_susp, res_status};
    end
  end

  assign stat.need_div = draw_used && !empty;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

/* src/ebfj_ctrl.sv */
// ----------------------------------------------------------------------------
// ebfj_ctrl
// Controller: sequences capture, remainder run and commit of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module ebfj_ctrl
  import ebfj_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire ebfj_stat_t stat,
  output ebfj_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  assign s_tready      = (state == ST_IDLE);
  assign cmd.accept    = (state == ST_IDLE) && s_tvalid;
  assign cmd.div_start = (state == ST_SETUP) && stat.need_div;
  assign cmd.commit    = (state == ST_FINISH) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_SETUP;
        end
        ST_SETUP: begin
          state <= stat.need_div ? ST_DIVIDE : ST_FINISH;
        end
        ST_DIVIDE: begin
          if (!stat.div_busy) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exponential backoff delay generator. A mirror
// of the settings, attempt count and ceiling predicts every result item; the
// sink compares each one field by field against the oldest prediction.
// Directed items cover the reset defaults, rejection, exhaustion, empty
// ranges and suspicious settings; random phases then run restart/backoff
// sequences under varied settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------

module tb_top;
  import ebfj_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [31:0] U32_ALL     = 32'hFFFF_FFFF;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] delay_ms;
    logic              suspicious;
    logic [WORD_W-1:0] attempts;
    logic [MS_W-1:0]   ceiling;
  } backoff_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [31:0]       s_tdata;   // [31:0] random_word
  logic [1:0]        s_tuser;   // [1:0] req_type
  logic              m_tvalid;
  logic              m_tready;
  logic [95:0]       m_tdata;   // [31:0] delay_ms, [63:32] attempts_done,
                                // [94:64] next_ceiling_ms, [95] zero
  logic [2:0]        m_tuser;   // [1:0] status, [2] settings_suspicious

  // mirror of settings and generator state
  logic [MS_W-1:0]   min_ms, init_ms, max_ms, ceil_ms;
  logic [WORD_W-1:0] limit_cnt, attempt_cnt;
  logic              retry_all;

  backoff_result_t   expected_backoffs[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       gap_max;
  int unsigned       stall_max;

  exponential_backoff_full_jitter_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // first word at or above which a draw over span values is refused
  function automatic logic [31:0] reject_cut(input logic [31:0] span);
    return U32_ALL - (U32_ALL % span);
  endfunction

  // uniform draw in [lo,hi]; 0 when the word is refused
  function automatic bit draw_span(input logic [31:0] lo, input logic [31:0] hi,
                                   input logic [31:0] word, output logic [31:0] pick);
    logic [31:0] span;
    pick = lo;
    if (lo >= hi) return 1'b1;
    span = hi - lo + 32'd1;
    if (word < reject_cut(span)) begin
      pick = lo + (word % span);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected result of one request; advances the mirrored state
  function automatic backoff_result_t predict_backoff(input logic [1:0] req,
                                                      input logic [31:0] word);
    backoff_result_t r;
    logic [31:0]     pick;
    r = '0;
    r.status = STAT_OK;
    case (req)
      REQ_NEXT: begin
        if (retry_all || attempt_cnt < limit_cnt) begin
          if (draw_span({1'b0, min_ms}, {1'b0, ceil_ms}, word, pick)) begin
            r.delay_ms = pick;
            if (ceil_ms < max_ms / 2) ceil_ms = {ceil_ms[MS_W-2:0], 1'b0};
            else ceil_ms = max_ms;
            attempt_cnt = attempt_cnt + 32'd1;
          end else begin
            r.status = STAT_REJECTED;
          end
        end else begin
          r.status   = STAT_EXHAUSTED;
          r.delay_ms = DELAY_INFINITE;
        end
      end
      REQ_RESTART: begin
        r.suspicious = (min_ms > init_ms) || (min_ms > max_ms) || (init_ms > max_ms);
        if (init_ms != '0) begin
          attempt_cnt = '0;
          ceil_ms     = init_ms;
        end else if (draw_span('0, {1'b0, max_ms}, word, pick)) begin
          attempt_cnt = '0;
          ceil_ms     = pick[MS_W-1:0];
        end else begin
          r.status = STAT_REJECTED;
        end
      end
      REQ_RANDOM: begin
        if (draw_span({1'b0, init_ms}, {1'b0, max_ms}, word, pick)) r.delay_ms = pick;
        else r.status = STAT_REJECTED;
      end
      default: ;
    endcase
    r.attempts = attempt_cnt;
    r.ceiling  = ceil_ms;
    return r;
  endfunction

  // random word, now and then right at the rejection threshold
  function automatic logic [31:0] choose_word(input logic [1:0] req);
    logic [31:0] lo, hi;
    lo = {1'b0, init_ms};
    hi = {1'b0, max_ms};
    if (req == REQ_NEXT) begin
      lo = {1'b0, min_ms};
      hi = {1'b0, ceil_ms};
    end else if (req == REQ_RESTART) begin
      lo = '0;
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return U32_ALL;
      2, 3: begin
        if (lo < hi) return reject_cut(hi - lo + 32'd1) - 32'd1 + $urandom_range(0, 2);
      end
      default: ;
    endcase
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_ms();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1, 64);
      3: return $urandom_range(1, 100000);
      4: return $urandom;
      default: return (32'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return U32_ALL;
      2: return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s expected 0x%08h actual 0x%08h", $time, name, want, got);
    end
  endfunction

  // one request item: random gap, then hold until accepted
  task automatic send_request(input logic [1:0] req, input logic [31:0] word);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    expected_backoffs.push_back(predict_backoff(req, word));
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_backoffs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all five registers in a shuffled order while idle
  task automatic load_settings(input logic [31:0] min_v, input logic [31:0] init_v,
                               input logic [31:0] max_v, input logic [31:0] limit_v,
                               input logic [31:0] retry_v);
    logic [CIDX_W-1:0] order [5];
    logic [CIDX_W-1:0] t;
    logic [31:0]       v;
    int unsigned       j;
    order = '{CFG_MIN_DELAY, CFG_INIT_CEILING, CFG_MAX_DELAY, CFG_ATTEMPT_LIMIT,
              CFG_RETRY_FOREVER};
    for (int i = 4; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    wait_drained();
    for (int k = 0; k < 5; k++) begin
      case (order[k])
        CFG_MIN_DELAY:     v = min_v;
        CFG_INIT_CEILING:  v = init_v;
        CFG_MAX_DELAY:     v = max_v;
        CFG_ATTEMPT_LIMIT: v = limit_v;
        default:           v = retry_v;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= v;
      do @(posedge clk); while (!cfg_ready);
      case (order[k])
        CFG_MIN_DELAY:     min_ms    = v[MS_W-1:0];
        CFG_INIT_CEILING:  init_ms   = v[MS_W-1:0];
        CFG_MAX_DELAY:     max_ms    = v[MS_W-1:0];
        CFG_ATTEMPT_LIMIT: limit_cnt = v;
        default:           retry_all = v[0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // settings straight out of reset: everything zero
  task automatic test_reset_defaults();
    send_request(REQ_NEXT, '0);
    send_request(REQ_RESTART, U32_ALL);
    send_request(REQ_RANDOM, U32_ALL);
    send_request(REQ_UNUSED, $urandom);
  endtask

  task automatic test_directed_cases();
    // short sequence: rejection, growth, exhaustion
    load_settings(32'd5, 32'd10, 32'd100, 32'd3, 32'd0);
    send_request(REQ_RESTART, '0);
    send_request(REQ_NEXT, U32_ALL);
    send_request(REQ_NEXT, '0);
    send_request(REQ_NEXT, $urandom);
    send_request(REQ_NEXT, $urandom);
    send_request(REQ_NEXT, $urandom);
    send_request(REQ_RANDOM, '0);
    send_request(REQ_RANDOM, U32_ALL);
    // suspicious settings, random ceiling refused then taken, empty range
    load_settings(32'd200, 32'd0, 32'd100, 32'd1, 32'd1);
    send_request(REQ_RESTART, U32_ALL);
    send_request(REQ_RESTART, 32'd7);
    send_request(REQ_NEXT, $urandom);
    // widest range: half the words are refused
    load_settings(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, U32_ALL, 32'd0);
    send_request(REQ_RESTART, $urandom);
    send_request(REQ_NEXT, 32'h8000_0000);
    send_request(REQ_NEXT, 32'h7FFF_FFFF);
    send_request(REQ_RANDOM, '0);
    // largest min over zero ceiling, retry forever
    load_settings(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, U32_ALL);
    send_request(REQ_RESTART, '0);
    send_request(REQ_NEXT, $urandom);
    // top data bit set on the narrower registers
    load_settings(U32_ALL, 32'h8000_0004, 32'h8000_0040, 32'd2, 32'hFFFF_FFFE);
    send_request(REQ_RESTART, $urandom);
    send_request(REQ_NEXT, $urandom);
  endtask

  task automatic test_random_phases();
    logic [31:0] a, b, c, t;
    logic [1:0]  req;
    int unsigned sent, steps;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: load_settings('0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, U32_ALL, 32'd1);
        1: load_settings(U32_ALL, '0, '0, '0, '0);
        default: begin
          a = pick_ms();
          b = pick_ms();
          c = pick_ms();
          // mostly well-ordered min <= initial <= max
          if ($urandom_range(0, 4) > 1) begin
            a[31] = 1'b0;
            b[31] = 1'b0;
            c[31] = 1'b0;
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
            if ($urandom_range(0, 5) == 0) b = '0;
          end
          load_settings(a, b, c, pick_limit(), $urandom);
        end
      endcase
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 11;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 4) != 0) begin
          // restart followed by a run of backoffs
          send_request(REQ_RESTART, choose_word(REQ_RESTART));
          steps = $urandom_range(1, 12);
          sent += steps + 1;
          repeat (steps) begin
            if ($urandom_range(0, 3) == 0) send_request(REQ_RANDOM, choose_word(REQ_RANDOM));
            else send_request(REQ_NEXT, choose_word(REQ_NEXT));
          end
        end else begin
          req = $urandom_range(0, 3);
          send_request(req, choose_word(req));
          if (req != REQ_UNUSED) sent++;
        end
      end
    end
  endtask

  // result sink: random stalls, checks every accepted item
  initial begin : result_sink
    int unsigned     stall;
    backoff_result_t want, got;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.status     = m_tuser[1:0];
      got.suspicious = m_tuser[2];
      got.delay_ms   = m_tdata[31:0];
      got.attempts   = m_tdata[63:32];
      got.ceiling    = m_tdata[94:64];
      if (expected_backoffs.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result item, expected none actual 0x%h",
                 $time, got);
      end else begin
        want = expected_backoffs.pop_front();
        check_field("status", want.status, got.status);
        check_field("delay_ms", want.delay_ms, got.delay_ms);
        check_field("settings_suspicious", want.suspicious, got.suspicious);
        check_field("attempts_done", want.attempts, got.attempts);
        check_field("next_ceiling_ms", want.ceiling, got.ceiling);
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MIN_DELAY;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_NEXT;
    gap_max     = 11;
    stall_max   = 11;
    min_ms      = '0;
    init_ms     = '0;
    max_ms      = '0;
    ceil_ms     = '0;
    limit_cnt   = '0;
    attempt_cnt = '0;
    retry_all   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_random_phases();

    wait_drained();
    repeat (40) @(posedge clk);
    if (expected_backoffs.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d results never arrived", $time, expected_backoffs.size());
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
